@@ rtl/dpbp_pkg.sv @@
package dpbp_pkg;

   localparam int SIZE_W     = 12;
   localparam int CENTER_W   = 13;
   localparam int INV_W      = 24;
   localparam int DEPTH_W    = 16;
   localparam int COLOR_W    = 8;
   localparam int XY_W       = 24;
   localparam int RGB_W      = 24;
   localparam int FRAC_W     = 25;
   localparam int CSR_DATA_W = 24;
   localparam int CSR_IDX_W  = 3;

   // register map
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CX_HALF      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CY_HALF      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_INV_FX       = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_INV_FY       = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_DEPTH    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_DEPTH    = 3'd7;

   // reset values
   localparam int FRAME_WIDTH_RST  = 640;
   localparam int FRAME_HEIGHT_RST = 480;
   localparam logic [CENTER_W-1:0] CX_HALF_RST   = 13'd640;
   localparam logic [CENTER_W-1:0] CY_HALF_RST   = 13'd480;
   localparam logic [INV_W-1:0]    INV_FX_RST    = 24'd31957;
   localparam logic [INV_W-1:0]    INV_FY_RST    = 24'd31957;
   localparam logic [DEPTH_W-1:0]  MIN_DEPTH_RST = 16'd100;
   localparam logic [DEPTH_W-1:0]  MAX_DEPTH_RST = 16'd10000;

   // rounding and saturation of the projected coordinate
   localparam int ROUND_ADD  = (1 << FRAC_W) - 1;
   localparam int XY_POS_MAX = 8388607;
   localparam int XY_NEG_MAG = 8388608;
   localparam logic [XY_W-1:0] XY_SAT_HI = 24'h7FFFFF;
   localparam logic [XY_W-1:0] XY_SAT_LO = 24'h800000;

   typedef struct packed {
      logic [CENTER_W-1:0] cx_half;
      logic [CENTER_W-1:0] cy_half;
      logic [INV_W-1:0]    inv_fx;
      logic [INV_W-1:0]    inv_fy;
      logic [DEPTH_W-1:0]  min_depth;
      logic [DEPTH_W-1:0]  max_depth;
   } cfg_type;

   typedef struct packed {
      logic accept;
      logic mul1;
      logic mul2;
      logic load_out;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_stat_type;

endpackage

@@ rtl/dpbp_req_if.sv @@
interface dpbp_req_if
   import dpbp_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [DEPTH_W-1:0] depth_mm;
   logic [COLOR_W-1:0] red;
   logic [COLOR_W-1:0] green;
   logic [COLOR_W-1:0] blue;

   modport source (output valid, depth_mm, red, green, blue, input ready);
   modport sink   (input valid, depth_mm, red, green, blue, output ready);
endinterface

@@ rtl/dpbp_rsp_if.sv @@
interface dpbp_rsp_if
   import dpbp_pkg::*;
   ();
   logic                   valid;
   logic                   ready;
   logic                   point_valid;
   logic signed [XY_W-1:0] x_mm;
   logic signed [XY_W-1:0] y_mm;
   logic [DEPTH_W-1:0]     z_mm;
   logic [RGB_W-1:0]       packed_rgb;
   logic                   frame_last;

   modport source (output valid, point_valid, x_mm, y_mm, z_mm, packed_rgb, frame_last,
                   input ready);
   modport sink   (input valid, point_valid, x_mm, y_mm, z_mm, packed_rgb, frame_last,
                   output ready);
endinterface

@@ rtl/dpbp_csr.sv @@
module dpbp_csr
   import dpbp_pkg::*;
#(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_en,
   input  logic [CSR_IDX_W-1:0]                csr_index,
   input  logic [CSR_DATA_W-1:0]               csr_wdata,
   output cfg_type                             cfg,
   output logic [$clog2(MAX_WIDTH):0]          width_lim,
   output logic [$clog2(MAX_HEIGHT):0]         height_lim
);

   localparam int WL_W = $clog2(MAX_WIDTH) + 1;
   localparam int HL_W = $clog2(MAX_HEIGHT) + 1;
   localparam logic [WL_W-1:0] WIDTH_RST =
      WL_W'((FRAME_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : FRAME_WIDTH_RST);
   localparam logic [HL_W-1:0] HEIGHT_RST =
      HL_W'((FRAME_HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : FRAME_HEIGHT_RST);

   logic [SIZE_W-1:0] wr_size;
   logic [WL_W-1:0]   width_in;
   logic [HL_W-1:0]   height_in;
   logic [WL_W-1:0]   width_ff;
   logic [HL_W-1:0]   height_ff;
   cfg_type           cfg_ff;

   assign wr_size = csr_wdata[SIZE_W-1:0];

   // clamp frame sizes once, on the write
   always_comb begin
      if (wr_size == '0) begin
         width_in  = WL_W'(1);
         height_in = HL_W'(1);
      end else begin
         if (32'(wr_size) > 32'(MAX_WIDTH)) begin
            width_in = WL_W'(MAX_WIDTH);
         end else begin
            width_in = WL_W'(wr_size);
         end
         if (32'(wr_size) > 32'(MAX_HEIGHT)) begin
            height_in = HL_W'(MAX_HEIGHT);
         end else begin
            height_in = HL_W'(wr_size);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff         <= WIDTH_RST;
         height_ff        <= HEIGHT_RST;
         cfg_ff.cx_half   <= CX_HALF_RST;
         cfg_ff.cy_half   <= CY_HALF_RST;
         cfg_ff.inv_fx    <= INV_FX_RST;
         cfg_ff.inv_fy    <= INV_FY_RST;
         cfg_ff.min_depth <= MIN_DEPTH_RST;
         cfg_ff.max_depth <= MAX_DEPTH_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            REG_FRAME_WIDTH:  width_ff         <= width_in;
            REG_FRAME_HEIGHT: height_ff        <= height_in;
            REG_CX_HALF:      cfg_ff.cx_half   <= csr_wdata[CENTER_W-1:0];
            REG_CY_HALF:      cfg_ff.cy_half   <= csr_wdata[CENTER_W-1:0];
            REG_INV_FX:       cfg_ff.inv_fx    <= csr_wdata[INV_W-1:0];
            REG_INV_FY:       cfg_ff.inv_fy    <= csr_wdata[INV_W-1:0];
            REG_MIN_DEPTH:    cfg_ff.min_depth <= csr_wdata[DEPTH_W-1:0];
            REG_MAX_DEPTH:    cfg_ff.max_depth <= csr_wdata[DEPTH_W-1:0];
            default: ;
         endcase
      end
   end

   assign cfg        = cfg_ff;
   assign width_lim  = width_ff;
   assign height_lim = height_ff;

endmodule

@@ rtl/dpbp_ctrl.sv @@
module dpbp_ctrl
   import dpbp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL1 = 2'd1;
   localparam logic [1:0] ST_MUL2 = 2'd2;
   localparam logic [1:0] ST_FIN  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_MUL1;
         ST_MUL1: state_in = ST_MUL2;
         ST_MUL2: state_in = ST_FIN;
         ST_FIN:  if (stat.out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready    = (state_ff == ST_IDLE);
   assign cmd.accept   = req_ready && req_valid;
   assign cmd.mul1     = (state_ff == ST_MUL1);
   assign cmd.mul2     = (state_ff == ST_MUL2);
   // hold the finished point until the output register frees up
   assign cmd.load_out = (state_ff == ST_FIN) && stat.out_free;

endmodule

@@ rtl/dpbp_dpath.sv @@
module dpbp_dpath
   import dpbp_pkg::*;
#(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  logic                        clock,
   input  logic                        reset,
   input  dp_cmd_type                  cmd,
   output dp_stat_type                 stat,
   input  cfg_type                     cfg,
   input  logic [$clog2(MAX_WIDTH):0]  width_lim,
   input  logic [$clog2(MAX_HEIGHT):0] height_lim,
   input  logic [DEPTH_W-1:0]          req_depth_mm,
   input  logic [COLOR_W-1:0]          req_red,
   input  logic [COLOR_W-1:0]          req_green,
   input  logic [COLOR_W-1:0]          req_blue,
   input  logic                        rsp_ready,
   output logic                        rsp_valid,
   output logic                        rsp_point_valid,
   output logic signed [XY_W-1:0]      rsp_x_mm,
   output logic signed [XY_W-1:0]      rsp_y_mm,
   output logic [DEPTH_W-1:0]          rsp_z_mm,
   output logic [RGB_W-1:0]            rsp_packed_rgb,
   output logic                        rsp_frame_last
);

   localparam int CW   = $clog2(MAX_WIDTH);
   localparam int RW   = $clog2(MAX_HEIGHT);
   localparam int WL_W = CW + 1;
   localparam int HL_W = RW + 1;
   localparam int PMAX = (CW > RW) ? CW : RW;
   localparam int OW   = (((PMAX + 1) > CENTER_W) ? (PMAX + 1) : CENTER_W) + 1;
   localparam int MGW  = OW - 1;
   localparam int P1W  = MGW + DEPTH_W;
   localparam int P2W  = P1W + INV_W;
   localparam int QW   = P2W + 1 - FRAC_W;

   // floor of a signed product over 2^FRAC_W, saturated to XY_W bits
   function automatic logic [XY_W-1:0] round_sat(input logic [P2W-1:0] prod,
                                                 input logic neg);
      logic [P2W:0]   sum;
      logic [QW-1:0]  q;
      logic [XY_W-1:0] res;
      sum = neg ? ({1'b0, prod} + (P2W+1)'(ROUND_ADD)) : {1'b0, prod};
      q   = sum[P2W:FRAC_W];
      if (!neg) begin
         res = (q > QW'(XY_POS_MAX)) ? XY_SAT_HI : q[XY_W-1:0];
      end else begin
         res = (q > QW'(XY_NEG_MAG)) ? XY_SAT_LO : (~q[XY_W-1:0] + XY_W'(1));
      end
      return res;
   endfunction

   logic [CW-1:0]      col_ff, col_in;
   logic [RW-1:0]      row_ff, row_in;
   logic               row_end, frame_end;
   logic               depth_ok;
   logic [OW-1:0]      off_x, off_y;
   logic [MGW-1:0]     mag_x, mag_y;

   logic [DEPTH_W-1:0] depth_ff;
   logic [RGB_W-1:0]   rgb_ff;
   logic               pv_ff, last_ff;
   logic               negx_ff, negy_ff;
   logic [MGW-1:0]     magx_ff, magy_ff;
   logic [P1W-1:0]     p1x_ff, p1y_ff;
   logic [P2W-1:0]     p2x_ff, p2y_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               pv_out_ff, last_out_ff;
   logic [XY_W-1:0]    x_out_ff, y_out_ff;
   logic [DEPTH_W-1:0] z_out_ff;
   logic [RGB_W-1:0]   rgb_out_ff;

   // pixel position
   assign row_end   = (WL_W'(col_ff) + WL_W'(1)) >= width_lim;
   assign frame_end = row_end && ((HL_W'(row_ff) + HL_W'(1)) >= height_lim);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (row_end) begin
         col_in = '0;
         row_in = frame_end ? '0 : row_ff + RW'(1);
      end else begin
         col_in = col_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (cmd.accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // offset from the principal point, as sign and magnitude
   assign depth_ok = (req_depth_mm > cfg.min_depth) && (req_depth_mm <= cfg.max_depth);
   assign off_x    = OW'({col_ff, 1'b0}) - OW'(cfg.cx_half);
   assign off_y    = OW'({row_ff, 1'b0}) - OW'(cfg.cy_half);
   assign mag_x    = off_x[OW-1] ? MGW'(~off_x + OW'(1)) : off_x[MGW-1:0];
   assign mag_y    = off_y[OW-1] ? MGW'(~off_y + OW'(1)) : off_y[MGW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         depth_ff <= req_depth_mm;
         rgb_ff   <= {req_red, req_green, req_blue};
         pv_ff    <= depth_ok;
         last_ff  <= frame_end;
         negx_ff  <= off_x[OW-1];
         negy_ff  <= off_y[OW-1];
         magx_ff  <= mag_x;
         magy_ff  <= mag_y;
      end
      if (cmd.mul1) begin
         p1x_ff <= P1W'(magx_ff) * P1W'(depth_ff);
         p1y_ff <= P1W'(magy_ff) * P1W'(depth_ff);
      end
      if (cmd.mul2) begin
         p2x_ff <= P2W'(p1x_ff) * P2W'(cfg.inv_fx);
         p2y_ff <= P2W'(p1y_ff) * P2W'(cfg.inv_fy);
      end
      if (cmd.load_out) begin
         pv_out_ff   <= pv_ff;
         x_out_ff    <= pv_ff ? round_sat(p2x_ff, negx_ff) : '0;
         y_out_ff    <= pv_ff ? round_sat(p2y_ff, negy_ff) : '0;
         z_out_ff    <= pv_ff ? depth_ff : '0;
         rgb_out_ff  <= rgb_ff;
         last_out_ff <= last_ff;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign stat.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_point_valid = pv_out_ff;
   assign rsp_x_mm        = $signed(x_out_ff);
   assign rsp_y_mm        = $signed(y_out_ff);
   assign rsp_z_mm        = z_out_ff;
   assign rsp_packed_rgb  = rgb_out_ff;
   assign rsp_frame_last  = last_out_ff;

endmodule

@@ rtl/depth_pixel_back_projection_core.sv @@
// Pinhole back projection of a row-major depth + RGB pixel stream into points.
// req_if (sink): one pixel per transfer, depth_mm plus red, green and blue.
// rsp_if (source): one point per pixel, in order: point_valid, x_mm, y_mm,
//   z_mm, packed_rgb (0xRRGGBB) and frame_last on the last pixel of a frame.
// csr_*: write-only register port, one register per cycle; the user writes only
//   while idle; the block does not enforce it. The controller walks accept, the
//   offset*depth multiply, the *inv_f multiply and round/saturate per pixel,
//   which loads the output register and rsp_if.valid; a new pixel waits for it.
// The output register lets the next pixel enter while a point waits.
// Receiver stall: the finished point holds in the output register and the
//   next pixel waits in the round/saturate step; no data is dropped.
// Reset (synchronous, active high): registers return to their defaults
//   (640x480, center 640/480, 1/f = 31957, depth range 101..10000 mm),
//   the column and row counters clear and the output channel empties.
module depth_pixel_back_projection_core
   import dpbp_pkg::*;
#(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  logic                  clock,
   input  logic                  reset,
   dpbp_req_if.sink              req_if,
   dpbp_rsp_if.source            rsp_if,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type                     cfg;
   logic [$clog2(MAX_WIDTH):0]  width_lim;
   logic [$clog2(MAX_HEIGHT):0] height_lim;
   dp_cmd_type                  cmd;
   dp_stat_type                 stat;

   // register file; frame sizes are clamped to 1..MAX on the write
   dpbp_csr #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg),
      .width_lim    (width_lim),
      .height_lim   (height_lim)
   );

   // sequencer: accept, two multiply steps, then load the output register
   dpbp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // position counters, multipliers, rounding and the output register
   dpbp_dpath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .cfg             (cfg),
      .width_lim       (width_lim),
      .height_lim      (height_lim),
      .req_depth_mm    (req_if.depth_mm),
      .req_red         (req_if.red),
      .req_green       (req_if.green),
      .req_blue        (req_if.blue),
      .rsp_ready       (rsp_if.ready),
      .rsp_valid       (rsp_if.valid),
      .rsp_point_valid (rsp_if.point_valid),
      .rsp_x_mm        (rsp_if.x_mm),
      .rsp_y_mm        (rsp_if.y_mm),
      .rsp_z_mm        (rsp_if.z_mm),
      .rsp_packed_rgb  (rsp_if.packed_rgb),
      .rsp_frame_last  (rsp_if.frame_last)
   );

endmodule
